>>> src/dque_pkg.sv
// shared types, sizes and codes for the double-ended task queue
package dque_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = $clog2(2 * DEPTH);
    localparam int WORD_W = 32;
    localparam int ENTRY_W = 2 * WORD_W;
    localparam int HELD_W = 5;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_PEEK_BACK  = 3'd4,
        OP_PEEK_FRONT = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // bookkeeping of a request in the read stage; read marks one whose ring read is returning
    typedef struct packed {
        logic    valid;
        logic    read;
        status_t status;
        cnt_t    held;
    } resp_t;

endpackage

>>> src/dque_ram.sv
// single-port ring store with registered read data
module dque_ram #(
    parameter int DATA_W = 64,
    parameter int WORDS  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

>>> src/double_ended_task_queue.sv
// double-ended task queue: circular deque of task entries over a ring store
//
// Requests arrive on the in_ channel (opcode, task_function, task_parameter)
// and each one gives exactly one result on the out_ channel (out_function,
// out_parameter, status, entries_held). A transfer happens at a rising edge
// where valid is high and stall is low.
// A result passes through the ring store read stage and then the output
// register. A new request can be taken every cycle while in_stall is low;
// the single ring port serves either the write of a push or the read of a
// pop or peek, so one request per cycle is the rate.
// Front index and occupancy are updated in the cycle a request is taken, so
// the next request sees them at once. A read issued after a write to the same
// entry always sees the new data.
// When the receiver stalls, the result holds in the output register and the
// next one waits in the read stage; in_stall rises only when both are full.
// Reset (rst_n low) empties the queue: front index and occupancy go to zero.
// Ring contents are not cleared; only entries written by pushes are read.
module double_ended_task_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            opcode,
    input  dque_pkg::word_t       task_function,
    input  dque_pkg::word_t       task_parameter,
    output logic                  out_valid,
    input  logic                  out_stall,
    output dque_pkg::word_t       out_function,
    output dque_pkg::word_t       out_parameter,
    output logic [1:0]            status,
    output logic [dque_pkg::HELD_W-1:0] entries_held
);
    import dque_pkg::*;

    idx_t  front_reg, front_next;
    cnt_t  occ_reg, occ_next;
    resp_t s1_reg, s1_next;
    logic  out_valid_reg, out_valid_next;
    word_t out_function_reg, out_parameter_reg;
    logic [1:0] status_reg;
    logic [HELD_W-1:0] held_reg;

    logic accept, s1_move, out_busy;
    logic ram_we, ram_re;
    idx_t ram_addr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [SUM_W-1:0] sum_back, sum_last;
    idx_t back_slot, last_slot, front_dec, front_inc;
    logic is_full, is_empty;

    assign out_busy = out_valid_reg && out_stall;
    assign s1_move  = s1_reg.valid && !out_busy;
    assign in_stall = s1_reg.valid && out_busy;
    assign accept   = in_valid && !in_stall;

    assign is_full  = (occ_reg == cnt_t'(DEPTH));
    assign is_empty = (occ_reg == '0);

    // slot just past the back and slot of the back entry, wrapped once
    assign sum_back  = SUM_W'(front_reg) + SUM_W'(occ_reg);
    assign sum_last  = sum_back - SUM_W'(1);
    assign back_slot = (sum_back >= SUM_W'(DEPTH)) ? IDX_W'(sum_back - SUM_W'(DEPTH))
                                                   : IDX_W'(sum_back);
    assign last_slot = (sum_last >= SUM_W'(DEPTH)) ? IDX_W'(sum_last - SUM_W'(DEPTH))
                                                   : IDX_W'(sum_last);
    assign front_dec = (front_reg == '0) ? idx_t'(DEPTH - 1) : front_reg - idx_t'(1);
    assign front_inc = (front_reg == idx_t'(DEPTH - 1)) ? '0 : front_reg + idx_t'(1);

    always_comb
    begin
        front_next     = front_reg;
        occ_next       = occ_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = front_reg;
        s1_next        = s1_reg;
        s1_next.valid  = s1_reg.valid && !s1_move;
        if (accept)
        begin
            s1_next.valid  = 1'b1;
            s1_next.read   = 1'b0;
            s1_next.status = ST_DONE;
            case (opcode)
                OP_PUSH_BACK, OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        s1_next.status = ST_FULL;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        occ_next = occ_reg + cnt_t'(1);
                        if (opcode == OP_PUSH_BACK)
                        begin
                            ram_addr = back_slot;
                        end
                        else
                        begin
                            ram_addr   = front_dec;
                            front_next = front_dec;
                        end
                    end
                end
                OP_POP_BACK, OP_POP_FRONT, OP_PEEK_BACK, OP_PEEK_FRONT:
                begin
                    if (is_empty)
                    begin
                        s1_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        ram_re       = 1'b1;
                        s1_next.read = 1'b1;
                        if (opcode == OP_POP_BACK || opcode == OP_PEEK_BACK)
                        begin
                            ram_addr = last_slot;
                        end
                        if (opcode == OP_POP_FRONT)
                        begin
                            front_next = front_inc;
                        end
                        if (opcode == OP_POP_BACK || opcode == OP_POP_FRONT)
                        begin
                            occ_next = occ_reg - cnt_t'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            s1_next.held = occ_next;
        end
    end

    assign out_valid_next = s1_move ? 1'b1 : (out_busy ? 1'b1 : 1'b0);

    dque_ram #(
        .DATA_W(ENTRY_W),
        .WORDS (DEPTH),
        .ADDR_W(IDX_W)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .re   (ram_re),
        .addr (ram_addr),
        .wdata({task_function, task_parameter}),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            occ_reg       <= '0;
            s1_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            s1_reg        <= s1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded as the read stage hands over
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_function_reg  <= s1_reg.read ? ram_rdata[ENTRY_W-1:WORD_W] : '0;
            out_parameter_reg <= s1_reg.read ? ram_rdata[WORD_W-1:0] : '0;
            status_reg        <= s1_reg.status;
            held_reg          <= HELD_W'(s1_reg.held);
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_function  = out_function_reg;
    assign out_parameter = out_parameter_reg;
    assign status        = status_reg;
    assign entries_held  = held_reg;

endmodule

>>> tb/double_ended_task_queue_test.sv
// self-checking testbench for the double-ended task queue
module double_ended_task_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dque_pkg::*;

    localparam int RANDOM_ITEMS = 1925;
    localparam int PHASE_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        opcode_t op;
        word_t   fn;
        word_t   pa;
    } task_request_t;

    typedef struct {
        word_t               fn;
        word_t               pa;
        status_t             st;
        logic [HELD_W-1:0]   held;
    } task_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [2:0]          opcode = '0;
    word_t               task_function = '0;
    word_t               task_parameter = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    word_t               out_function;
    word_t               out_parameter;
    logic [1:0]          status;
    logic [HELD_W-1:0]   entries_held;

    // shadow deque
    word_t ring_fn [DEPTH];
    word_t ring_pa [DEPTH];
    int    front_slot = 0;
    int    held_count = 0;

    task_request_t pending_requests[$];
    task_result_t  expected_results[$];
    task_request_t next_req;
    task_result_t  want;

    bit in_taken = 1'b0;
    int items_sent = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int dropped_pushes = 0;
    int empty_reads = 0;

    double_ended_task_queue uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .task_function  (task_function),
        .task_parameter (task_parameter),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_function   (out_function),
        .out_parameter  (out_parameter),
        .status         (status),
        .entries_held   (entries_held)
    );

    always #5 clk = ~clk;

    function automatic task_result_t apply_request(input task_request_t req);
        task_result_t res;
        int slot;
        res.fn = '0;
        res.pa = '0;
        res.st = ST_DONE;
        case (req.op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (held_count >= DEPTH)
                begin
                    res.st = ST_FULL;
                end
                else
                begin
                    if (req.op == OP_PUSH_BACK)
                    begin
                        slot = (front_slot + held_count) % DEPTH;
                    end
                    else
                    begin
                        front_slot = (front_slot + DEPTH - 1) % DEPTH;
                        slot = front_slot;
                    end
                    ring_fn[slot] = req.fn;
                    ring_pa[slot] = req.pa;
                    held_count++;
                end
            end
            OP_POP_BACK, OP_POP_FRONT, OP_PEEK_BACK, OP_PEEK_FRONT:
            begin
                if (held_count == 0)
                begin
                    res.st = ST_EMPTY;
                end
                else
                begin
                    if (req.op == OP_POP_BACK || req.op == OP_PEEK_BACK)
                        slot = (front_slot + held_count - 1) % DEPTH;
                    else
                        slot = front_slot;
                    res.fn = ring_fn[slot];
                    res.pa = ring_pa[slot];
                    if (req.op == OP_POP_FRONT)
                        front_slot = (front_slot + 1) % DEPTH;
                    if (req.op == OP_POP_BACK || req.op == OP_POP_FRONT)
                        held_count--;
                end
            end
            default:
            begin
            end
        endcase
        res.held = HELD_W'(held_count);
        return res;
    endfunction

    function automatic void add_request(input opcode_t op, input word_t fn, input word_t pa);
        task_request_t req;
        req.op = op;
        req.fn = fn;
        req.pa = pa;
        pending_requests.push_back(req);
    endfunction

    // phase rotation: none, sender idle, receiver stall, both light
    function automatic int send_idle_pct(input int sent);
        case ((sent / PHASE_ITEMS) % 4)
            1: return 67;
            3: return 13;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input int sent);
        case ((sent / PHASE_ITEMS) % 4)
            2: return 67;
            3: return 13;
            default: return 0;
        endcase
    endfunction

    // driver: new payload only after the previous transfer or while idle
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct(items_sent))
                begin
                    next_req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    opcode <= next_req.op;
                    task_function <= next_req.fn;
                    task_parameter <= next_req.pa;
                    items_sent++;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct(items_sent));
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing expected: status %0d held %0d",
                           status, entries_held);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (out_function !== want.fn)
                    begin
                        $error("out_function: expected %h, got %h", want.fn, out_function);
                        mismatches++;
                    end
                    if (out_parameter !== want.pa)
                    begin
                        $error("out_parameter: expected %h, got %h", want.pa, out_parameter);
                        mismatches++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        mismatches++;
                    end
                    if (entries_held !== want.held)
                    begin
                        $error("entries_held: expected %0d, got %0d", want.held, entries_held);
                        mismatches++;
                    end
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
            begin
                next_req.op = opcode_t'(opcode);
                next_req.fn = task_function;
                next_req.pa = task_parameter;
                want = apply_request(next_req);
                if (want.st == ST_FULL)
                    dropped_pushes++;
                if (want.st == ST_EMPTY)
                    empty_reads++;
                expected_results.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int push_pct;
        int pick;
        opcode_t op;

        // empty queue reads
        add_request(OP_POP_BACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(OP_POP_FRONT, '0, '0);
        add_request(OP_PEEK_BACK, 32'hDEAD_BEEF, '0);
        add_request(OP_PEEK_FRONT, '0, 32'hCAFE_F00D);
        // push front first so the front index wraps below zero
        add_request(OP_PUSH_FRONT, 32'hFFFF_FFFF, 32'h0000_0000);
        add_request(OP_PUSH_BACK, 32'h0000_0000, 32'hFFFF_FFFF);
        add_request(OP_PEEK_FRONT, '0, '0);
        add_request(OP_PEEK_BACK, '0, '0);
        for (int i = 0; i < DEPTH - 2; i++)
        begin
            if (i % 2 == 0)
                add_request(OP_PUSH_BACK, 32'hAAAA_AAAA ^ i, 32'h5555_5555 ^ i);
            else
                add_request(OP_PUSH_FRONT, 32'h5555_5555 ^ i, 32'hAAAA_AAAA ^ i);
        end
        // full queue pushes are dropped
        add_request(OP_PUSH_BACK, 32'h1234_5678, 32'h9ABC_DEF0);
        add_request(OP_PUSH_FRONT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        add_request(OP_POP_FRONT, '0, '0);
        add_request(OP_POP_BACK, '0, '0);

        // random walks with push or pop bias so the queue swings between empty and full
        push_pct = 50;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            pick = $urandom_range(99);
            if (pick < push_pct)
                op = ($urandom_range(1) == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else if ($urandom_range(3) != 0)
                op = ($urandom_range(1) == 0) ? OP_POP_BACK : OP_POP_FRONT;
            else
                op = ($urandom_range(1) == 0) ? OP_PEEK_BACK : OP_PEEK_FRONT;
            add_request(op, $urandom, $urandom);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results over %0d requests", results_checked, items_sent);
        $display("dropped pushes on full queue: %0d, reads of empty queue: %0d",
                 dropped_pushes, empty_reads);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
src/dque_pkg.sv
src/dque_ram.sv
src/double_ended_task_queue.sv
tb/double_ended_task_queue_test.sv
